[sv/vfrs_pkg.sv]
`default_nettype none

package vfrs_pkg;

  // Field widths
  localparam int FREQ_BITS = 20;
  localparam int STEP_BITS = 16;
  localparam int HOLD_BITS = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS = 16;

  // Working width for ramp sums and differences: one bit above the wider operand
  localparam int SUM_BITS = ((FREQ_BITS > STEP_BITS) ? FREQ_BITS : STEP_BITS) + 1;

  // Reset values of the configuration registers
  localparam logic [STEP_BITS-1:0] STEP_CHANGE_RST = STEP_BITS'(50);
  localparam logic [STEP_BITS-1:0] STEP_START_RST  = STEP_BITS'(200);
  localparam logic [STEP_BITS-1:0] STEP_STOP_RST   = STEP_BITS'(150);
  localparam logic [HOLD_BITS-1:0] DC_HOLD_RST     = HOLD_BITS'(100);

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_STEP_CHANGE = 2'd0,
    REG_STEP_START  = 2'd1,
    REG_STEP_STOP   = 2'd2,
    REG_DC_HOLD     = 2'd3
  } cfg_index_t;

  // Drive modes as reported on run_mode
  typedef enum logic [1:0] {
    MODE_STOPPED  = 2'd0,
    MODE_STARTING = 2'd1,
    MODE_RUNNING  = 2'd2,
    MODE_STOPPING = 2'd3
  } mode_t;

  typedef struct packed {
    logic [STEP_BITS-1:0] step_change;
    logic [STEP_BITS-1:0] step_start;
    logic [STEP_BITS-1:0] step_stop;
    logic [HOLD_BITS-1:0] dc_hold_ticks;
  } cfg_t;

  typedef struct packed {
    mode_t                mode;
    logic                 dir;
    logic [FREQ_BITS-1:0] freq;
    logic [HOLD_BITS-1:0] hold_count;
    logic                 pwm_active;
    logic                 reverse_pending;
  } ramp_state_t;

  typedef struct packed {
    logic [FREQ_BITS-1:0] target_freq;
    logic                 reverse_request;
  } in_word_t;

  typedef struct packed {
    logic [FREQ_BITS-1:0] freq_now;
    logic [1:0]           run_mode;
    logic                 reverse_dir;
    logic                 pwm_on;
    logic                 reverse_served;
  } out_word_t;

endpackage

`default_nettype wire

[sv/vfrs_cfg_regs.sv]
`default_nettype none

module vfrs_cfg_regs (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [vfrs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [vfrs_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output vfrs_pkg::cfg_t                           cfg
);

  // Writes are always taken
  assign cfg_ready = 1'b1;

  // Register file with decoded write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_change   <= vfrs_pkg::STEP_CHANGE_RST;
      cfg.step_start    <= vfrs_pkg::STEP_START_RST;
      cfg.step_stop     <= vfrs_pkg::STEP_STOP_RST;
      cfg.dc_hold_ticks <= vfrs_pkg::DC_HOLD_RST;
    end else if (cfg_valid) begin
      unique case (vfrs_pkg::cfg_index_t'(cfg_index))
        vfrs_pkg::REG_STEP_CHANGE: begin
          cfg.step_change <= vfrs_pkg::STEP_BITS'(cfg_data);
        end
        vfrs_pkg::REG_STEP_START: begin
          cfg.step_start <= vfrs_pkg::STEP_BITS'(cfg_data);
        end
        vfrs_pkg::REG_STEP_STOP: begin
          cfg.step_stop <= vfrs_pkg::STEP_BITS'(cfg_data);
        end
        vfrs_pkg::REG_DC_HOLD: begin
          cfg.dc_hold_ticks <= vfrs_pkg::HOLD_BITS'(cfg_data);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/vfrs_ramp_step.sv]
`default_nettype none

module vfrs_ramp_step (
  input  wire vfrs_pkg::cfg_t        cfg,
  input  wire vfrs_pkg::ramp_state_t cur,
  input  wire vfrs_pkg::in_word_t    word,
  output vfrs_pkg::ramp_state_t      nxt,
  output vfrs_pkg::out_word_t        res
);

  logic [vfrs_pkg::SUM_BITS-1:0] f_ext;
  logic [vfrs_pkg::SUM_BITS-1:0] tgt_ext;
  logic [vfrs_pkg::SUM_BITS-1:0] start_sum;
  logic [vfrs_pkg::SUM_BITS-1:0] change_up;
  logic [vfrs_pkg::SUM_BITS-1:0] change_dn;
  logic [vfrs_pkg::SUM_BITS-1:0] over_tgt;
  logic [vfrs_pkg::SUM_BITS-1:0] stop_dn;
  logic [vfrs_pkg::SUM_BITS-1:0] change_ext;
  logic [vfrs_pkg::SUM_BITS-1:0] stop_ext;
  logic                          pending;
  logic                          served;

  // Ramp arithmetic in a common width
  always_comb begin
    f_ext      = vfrs_pkg::SUM_BITS'(cur.freq);
    tgt_ext    = vfrs_pkg::SUM_BITS'(word.target_freq);
    change_ext = vfrs_pkg::SUM_BITS'(cfg.step_change);
    stop_ext   = vfrs_pkg::SUM_BITS'(cfg.step_stop);
    start_sum  = f_ext + vfrs_pkg::SUM_BITS'(cfg.step_start);
    change_up  = f_ext + change_ext;
    change_dn  = f_ext - change_ext;
    over_tgt   = f_ext - tgt_ext;
    stop_dn    = f_ext - stop_ext;
  end

  // Mode sequencing for one tick
  always_comb begin
    pending             = cur.reverse_pending | word.reverse_request;
    served              = 1'b0;
    nxt                 = cur;
    nxt.reverse_pending = pending;
    unique case (cur.mode)
      vfrs_pkg::MODE_STARTING: begin
        if (cur.freq == '0) begin
          nxt.pwm_active = 1'b1;
        end
        if (start_sum >= tgt_ext) begin
          nxt.freq = word.target_freq;
          nxt.mode = vfrs_pkg::MODE_RUNNING;
        end else begin
          nxt.freq = start_sum[vfrs_pkg::FREQ_BITS-1:0];
        end
      end
      vfrs_pkg::MODE_STOPPING: begin
        if (f_ext <= stop_ext) begin
          nxt.freq = '0;
          // DC hold at zero, then PWM off
          if (cur.hold_count == '0) begin
            nxt.pwm_active = 1'b0;
            nxt.mode       = vfrs_pkg::MODE_STOPPED;
          end else begin
            nxt.hold_count = cur.hold_count - vfrs_pkg::HOLD_BITS'(1);
          end
        end else begin
          nxt.freq = stop_dn[vfrs_pkg::FREQ_BITS-1:0];
        end
      end
      vfrs_pkg::MODE_RUNNING: begin
        if (f_ext < tgt_ext) begin
          if (change_up > tgt_ext) begin
            nxt.freq = word.target_freq;
          end else begin
            nxt.freq = change_up[vfrs_pkg::FREQ_BITS-1:0];
          end
        end else if (f_ext > tgt_ext) begin
          if (over_tgt < change_ext) begin
            nxt.freq = word.target_freq;
          end else begin
            nxt.freq = change_dn[vfrs_pkg::FREQ_BITS-1:0];
          end
        end
        // Reversal in run: ramp down first, reload DC hold
        if (pending) begin
          nxt.mode       = vfrs_pkg::MODE_STOPPING;
          nxt.hold_count = cfg.dc_hold_ticks;
        end
      end
      vfrs_pkg::MODE_STOPPED: begin
        if (pending) begin
          nxt.dir             = ~cur.dir;
          nxt.mode            = vfrs_pkg::MODE_STARTING;
          nxt.reverse_pending = 1'b0;
          served              = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Result word reflects state after the tick
  always_comb begin
    res.freq_now       = nxt.freq;
    res.run_mode       = nxt.mode;
    res.reverse_dir    = nxt.dir;
    res.pwm_on         = nxt.pwm_active;
    res.reverse_served = served;
  end

endmodule

`default_nettype wire

[sv/vfd_frequency_ramp_sequencer_core.sv]
`default_nettype none

// Channel | Dir | Handshake          | Word
// --------+-----+--------------------+---------------------------------------
// cfg     | in  | cfg_valid/ready    | cfg_index, cfg_data (register write)
// in      | in  | in_valid/in_stall  | in_word: target_freq, reverse_request
// out     | out | out_valid/out_stall| in order, one result word per tick
//
// One tick word per cycle sustained while out_stall is low; each word passes the
// input register, then the ramp/mode logic into the result register.
// rst is synchronous: stopped, forward, zero frequency, PWM off, config at
// its defaults. A stalled result word holds the result register; the input
// register keeps accepting until it too is occupied.
module vfd_frequency_ramp_sequencer_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [vfrs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [vfrs_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire vfrs_pkg::in_word_t                  in_word,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output vfrs_pkg::out_word_t                      out_word
);

  vfrs_pkg::cfg_t        cfg;
  vfrs_pkg::ramp_state_t state;
  vfrs_pkg::ramp_state_t state_next;
  vfrs_pkg::out_word_t   res_next;
  vfrs_pkg::in_word_t    in_reg;
  logic                  in_reg_valid;
  logic                  advance;
  logic                  take_in;

  vfrs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  vfrs_ramp_step u_step (
    .cfg  (cfg),
    .cur  (state),
    .word (in_reg),
    .nxt  (state_next),
    .res  (res_next)
  );

  // Pipeline flow control
  assign advance  = ~out_valid | ~out_stall;
  assign in_stall = in_reg_valid & ~advance;
  assign take_in  = in_valid & ~in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (take_in) begin
      in_reg_valid <= 1'b1;
    end else if (advance) begin
      in_reg_valid <= 1'b0;
    end
    if (take_in) begin
      in_reg <= in_word;
    end
  end

  // Ramp state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode            <= vfrs_pkg::MODE_STOPPED;
      state.dir             <= 1'b0;
      state.freq            <= '0;
      state.hold_count      <= '0;
      state.pwm_active      <= 1'b0;
      state.reverse_pending <= 1'b0;
      out_valid             <= 1'b0;
    end else if (advance) begin
      out_valid <= in_reg_valid;
      if (in_reg_valid) begin
        state <= state_next;
      end
    end
    if (advance && in_reg_valid) begin
      out_word <= res_next;
    end
  end

endmodule

`default_nettype wire
